@@ design/sxfb_pkg.sv @@
package sxfb_pkg;

   localparam int HIRES_WIDTH_DEF  = 128;
   localparam int HIRES_HEIGHT_DEF = 64;
   localparam int LORES_WIDTH_DEF  = 64;
   localparam int LORES_HEIGHT_DEF = 32;
   localparam int NUM_PLANES_DEF   = 2;

   localparam int NARROW_PIX = 8;
   localparam int WIDE_PIX   = 16;
   localparam logic [4:0] FLAG_MAX = 5'd16;

   localparam logic CSR_HIRES_MODE   = 1'b0;
   localparam logic CSR_PLANE_SELECT = 1'b1;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_DOWN   = 3'd1,
      OP_RIGHT  = 3'd2,
      OP_LEFT   = 3'd3,
      OP_NARROW = 3'd4,
      OP_WIDE   = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DRAW_RD,
      ST_DRAW_WR,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_FINISH
   } state_type;

   // Remainder of an 8-bit value by a divisor of at least 16: the quotient
   // is below 16, so four conditional subtracts of 8d, 4d, 2d and d suffice.
   function automatic logic [7:0] mod_small(input logic [7:0] v, input logic [8:0] d);
      logic [11:0] r;
      logic [11:0] s;
      r = 12'(v);
      for (int k = 3; k >= 0; k--) begin
         s = 12'(d) << k;
         if (r >= s) begin
            r = r - s;
         end
      end
      return r[7:0];
   endfunction

endpackage

@@ design/sxfb_row_ram.sv @@
module sxfb_row_ram
   import sxfb_pkg::*;
#(
   parameter int WIDTH  = LORES_WIDTH_DEF,
   parameter int ROWS   = LORES_HEIGHT_DEF,
   parameter int PLANES = NUM_PLANES_DEF,
   localparam int DEPTH = ROWS * PLANES,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear_en,
   input  logic             clear_plane,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_hit_ff;
   logic [DEPTH-1:0] valid_ff;

   // A row that was never written since reset or the last clear reads as zero.
   for (genvar i = 0; i < DEPTH; i++) begin : g_valid
      localparam int PL = i / ROWS;
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (clear_en && (2'(clear_plane) == 2'(PL))) begin
            valid_ff[i] <= 1'b0;
         end else if (wr_en && (wr_addr == AW'(i))) begin
            valid_ff[i] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

@@ design/sxfb_mask.sv @@
module sxfb_mask
   import sxfb_pkg::*;
#(
   parameter int MW = HIRES_WIDTH_DEF
) (
   input  logic [7:0]    x_start,
   input  logic [8:0]    width,
   input  logic          wide,
   input  logic [15:0]   bits,
   output logic [MW-1:0] mask,
   output logic          clip_hit
);

   always_comb begin
      logic [9:0] c;
      logic [9:0] col;
      logic       pix;
      mask     = '0;
      clip_hit = 1'b0;
      for (int j = 0; j < WIDE_PIX; j++) begin
         if (wide) begin
            pix = bits[WIDE_PIX-1-j];
         end else if (j < NARROW_PIX) begin
            pix = bits[NARROW_PIX-1-j];
         end else begin
            pix = 1'b0;
         end
         c = 10'(x_start) + 10'(j);
         if (!wide && (j > 0) && (c >= 10'(width))) begin
            clip_hit = clip_hit | pix;
         end else begin
            col = (c >= 10'(width)) ? (c - 10'(width)) : c;
            if (pix) begin
               mask = mask | (MW'(1) << col);
            end
         end
      end
   end

endmodule

@@ design/sprite_xor_frame_buffer_top.sv @@
// Flow: a sprite row is read in ST_DRAW_RD, XORed and written back in ST_DRAW_WR,
// and its result is registered in ST_FINISH; a clear passes ST_CLEAR then ST_FINISH.
// A scroll reads and writes back each bitmap row in turn (ST_SCR_RD, ST_SCR_WR)
// through the row memory's single port pair; a scroll that changes nothing and the
// unused opcodes go straight to ST_FINISH. One command is in flight at a time, and
// ST_FINISH waits while the output register holds an unaccepted result. Synchronous
// reset: bitmaps read as all zero, the hit count and both configuration registers clear.
module sprite_xor_frame_buffer_top
   import sxfb_pkg::*;
#(
   parameter int HIRES_WIDTH  = HIRES_WIDTH_DEF,
   parameter int HIRES_HEIGHT = HIRES_HEIGHT_DEF,
   parameter int LORES_WIDTH  = LORES_WIDTH_DEF,
   parameter int LORES_HEIGHT = LORES_HEIGHT_DEF,
   parameter int NUM_PLANES   = NUM_PLANES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [3:0]  req_row_index,
   input  logic [15:0] req_row_bits,
   input  logic [3:0]  req_scroll_amount,
   input  logic        req_last_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_draw_flag,
   output logic        rsp_flag_final,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic        csr_data
);

   localparam int MW  = (HIRES_WIDTH > LORES_WIDTH) ? HIRES_WIDTH : LORES_WIDTH;
   localparam int MH  = (HIRES_HEIGHT > LORES_HEIGHT) ? HIRES_HEIGHT : LORES_HEIGHT;
   localparam int RW  = $clog2(MH);
   localparam int HAW = $clog2(HIRES_HEIGHT * NUM_PLANES);
   localparam int LAW = $clog2(LORES_HEIGHT * NUM_PLANES);
   localparam logic MULTI = (NUM_PLANES > 1);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [7:0]  px_ff, py_ff;
   logic [3:0]  ri_ff, n_ff;
   logic [15:0] bits_ff;
   logic        last_ff;
   logic [RW-1:0] row_ff, row_in;
   logic [7:0]  xm_ff, xm_in;
   logic        clip_row_ff, clip_row_in;
   logic        src_ok_ff, src_ok_in;
   logic [4:0]  hit_cnt_ff, hit_cnt_in;
   logic [4:0]  res_flag_ff, res_flag_in;
   logic        res_final_ff, res_final_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_flag_ff, rsp_flag_in;
   logic        rsp_final_ff, rsp_final_in;
   logic        hires_ff, plane_ff;

   logic [8:0] cur_w;
   logic [7:0] cur_h;
   logic       plane_eff;
   logic       accept;
   logic       ram_clear, rd_en, wr_en;
   logic [RW-1:0] rd_row;
   logic [MW-1:0] wr_data, rd_data;
   logic [MW-1:0] mask;
   logic          clip_hit;
   logic [HAW-1:0] hi_rd_addr, hi_wr_addr;
   logic [LAW-1:0] lo_rd_addr, lo_wr_addr;
   logic [HIRES_WIDTH-1:0] hi_rd_data;
   logic [LORES_WIDTH-1:0] lo_rd_data;

   assign cur_w     = hires_ff ? 9'(HIRES_WIDTH) : 9'(LORES_WIDTH);
   assign cur_h     = hires_ff ? 8'(HIRES_HEIGHT) : 8'(LORES_HEIGHT);
   assign plane_eff = plane_ff & MULTI;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_draw_flag  = rsp_flag_ff;
   assign rsp_flag_final = rsp_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hires_ff <= 1'b0;
         plane_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HIRES_MODE:   hires_ff <= csr_data;
            CSR_PLANE_SELECT: plane_ff <= csr_data;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_cnt_ff   <= hit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_in;
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         ri_ff   <= req_row_index;
         bits_ff <= req_row_bits;
         n_ff    <= req_scroll_amount;
         last_ff <= req_last_row;
      end
      row_ff       <= row_in;
      xm_ff        <= xm_in;
      clip_row_ff  <= clip_row_in;
      src_ok_ff    <= src_ok_in;
      res_flag_ff  <= res_flag_in;
      res_final_ff <= res_final_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_final_ff <= rsp_final_in;
   end

   sxfb_mask #(.MW(MW)) u_mask (
      .x_start  (xm_ff),
      .width    (cur_w),
      .wide     (op_ff == OP_WIDE),
      .bits     (bits_ff),
      .mask     (mask),
      .clip_hit (clip_hit)
   );

   always_comb begin
      logic [8:0] y;
      logic [7:0] ym;
      logic [4:0] base;
      logic       hit;
      logic       lim;
      state_in     = state_ff;
      op_in        = op_type'(req_opcode);
      row_in       = row_ff;
      xm_in        = xm_ff;
      clip_row_in  = clip_row_ff;
      src_ok_in    = src_ok_ff;
      hit_cnt_in   = hit_cnt_ff;
      res_flag_in  = res_flag_ff;
      res_final_in = res_final_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_flag_in  = rsp_flag_ff;
      rsp_final_in = rsp_final_ff;
      ram_clear    = 1'b0;
      rd_en        = 1'b0;
      rd_row       = row_ff;
      wr_en        = 1'b0;
      wr_data      = '0;
      y            = '0;
      ym           = '0;
      base         = '0;
      hit          = 1'b0;
      lim          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            res_flag_in  = '0;
            res_final_in = 1'b0;
            row_in       = RW'(cur_h - 8'd1);
            if (accept) begin
               unique case (req_opcode)
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_DOWN, OP_RIGHT, OP_LEFT: begin
                     if (req_opcode == OP_DOWN) begin
                        lim = (8'(req_scroll_amount) >= cur_h);
                     end else begin
                        lim = (9'(req_scroll_amount) >= cur_w);
                     end
                     // A zero or full-size scroll leaves the bitmap as it is.
                     if (req_scroll_amount == 4'd0 || lim) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_SCR_RD;
                     end
                  end
                  OP_NARROW, OP_WIDE: state_in = ST_DRAW_RD;
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_CLEAR: begin
            ram_clear = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_DRAW_RD: begin
            xm_in = mod_small(px_ff, cur_w);
            ym    = mod_small(py_ff, {1'b0, cur_h});
            y     = 9'(ym) + 9'(ri_ff);
            if (y >= 9'(cur_h)) begin
               y = y - 9'(cur_h);
               clip_row_in = (op_ff == OP_NARROW) && (ri_ff != 4'd0);
            end else begin
               clip_row_in = 1'b0;
            end
            row_in   = RW'(y);
            rd_row   = RW'(y);
            rd_en    = 1'b1;
            state_in = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            // A narrow row below the bottom edge is dropped whole.
            if (clip_row_ff) begin
               hit = (bits_ff[7:0] != 8'd0);
            end else begin
               hit     = clip_hit | ((rd_data & mask) != '0);
               wr_en   = 1'b1;
               wr_data = rd_data ^ mask;
            end
            base = (ri_ff == 4'd0) ? 5'd0 : hit_cnt_ff;
            if (hit && base < FLAG_MAX) begin
               base = base + 5'd1;
            end
            hit_cnt_in   = base;
            res_flag_in  = hires_ff ? base : {4'd0, base != 5'd0};
            res_final_in = last_ff;
            state_in     = ST_FINISH;
         end
         ST_SCR_RD: begin
            if (op_ff == OP_DOWN) begin
               src_ok_in = (row_ff >= RW'(n_ff));
               rd_row    = row_ff - RW'(n_ff);
            end else begin
               src_ok_in = 1'b1;
               rd_row    = row_ff;
            end
            rd_en    = src_ok_in;
            state_in = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            wr_en = 1'b1;
            if (!src_ok_ff) begin
               wr_data = '0;
            end else if (op_ff == OP_RIGHT) begin
               wr_data = rd_data << n_ff;
            end else if (op_ff == OP_LEFT) begin
               wr_data = rd_data >> n_ff;
            end else begin
               wr_data = rd_data;
            end
            if (row_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               row_in   = row_ff - RW'(1);
               state_in = ST_SCR_RD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = res_flag_ff;
               rsp_final_in = res_final_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign hi_rd_addr = HAW'(rd_row) + (plane_eff ? HAW'(HIRES_HEIGHT) : HAW'(0));
   assign hi_wr_addr = HAW'(row_ff) + (plane_eff ? HAW'(HIRES_HEIGHT) : HAW'(0));
   assign lo_rd_addr = LAW'(rd_row) + (plane_eff ? LAW'(LORES_HEIGHT) : LAW'(0));
   assign lo_wr_addr = LAW'(row_ff) + (plane_eff ? LAW'(LORES_HEIGHT) : LAW'(0));

   assign rd_data = hires_ff ? MW'(hi_rd_data) : MW'(lo_rd_data);

   sxfb_row_ram #(
      .WIDTH  (HIRES_WIDTH),
      .ROWS   (HIRES_HEIGHT),
      .PLANES (NUM_PLANES)
   ) u_hires_ram (
      .clock       (clock),
      .reset       (reset),
      .clear_en    (ram_clear & hires_ff),
      .clear_plane (plane_eff),
      .rd_en       (rd_en & hires_ff),
      .rd_addr     (hi_rd_addr),
      .rd_data     (hi_rd_data),
      .wr_en       (wr_en & hires_ff),
      .wr_addr     (hi_wr_addr),
      .wr_data     (HIRES_WIDTH'(wr_data))
   );

   sxfb_row_ram #(
      .WIDTH  (LORES_WIDTH),
      .ROWS   (LORES_HEIGHT),
      .PLANES (NUM_PLANES)
   ) u_lores_ram (
      .clock       (clock),
      .reset       (reset),
      .clear_en    (ram_clear & ~hires_ff),
      .clear_plane (plane_eff),
      .rd_en       (rd_en & ~hires_ff),
      .rd_addr     (lo_rd_addr),
      .rd_data     (lo_rd_data),
      .wr_en       (wr_en & ~hires_ff),
      .wr_addr     (lo_wr_addr),
      .wr_data     (LORES_WIDTH'(wr_data))
   );

endmodule

@@ bench/sxfb_checker.sv @@
`timescale 1ns / 1ps
module sxfb_checker
   import sxfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [3:0]  req_row_index,
   input  logic [15:0] req_row_bits,
   input  logic [3:0]  req_scroll_amount,
   input  logic        req_last_row,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [4:0]  rsp_draw_flag,
   input  logic        rsp_flag_final,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic        csr_data,
   output int          fail_count,
   output int          pending_flags
);
   localparam int HW = HIRES_WIDTH_DEF;
   localparam int HH = HIRES_HEIGHT_DEF;
   localparam int LW = LORES_WIDTH_DEF;
   localparam int LH = LORES_HEIGHT_DEF;

   typedef struct packed {
      logic [4:0] draw_flag;
      logic       flag_final;
   } flag_type;

   bit   hi_pix [NUM_PLANES_DEF][HH][HW];
   bit   lo_pix [NUM_PLANES_DEF][LH][LW];
   logic [4:0] hit_rows;
   logic hires_cfg;
   logic plane_cfg;
   flag_type flag_queue[$];

   assign pending_flags = flag_queue.size();

   function automatic bit get_pix(int r, int c);
      if (hires_cfg) return hi_pix[plane_cfg][r][c];
      return lo_pix[plane_cfg][r][c];
   endfunction

   function automatic void put_pix(int r, int c, bit v);
      if (hires_cfg) hi_pix[plane_cfg][r][c] = v;
      else lo_pix[plane_cfg][r][c] = v;
   endfunction

   function automatic flag_type predict_flag(logic [2:0] op, logic [7:0] px, logic [7:0] py,
                                             logic [3:0] ri, logic [15:0] bits,
                                             logic [3:0] n, logic lastr);
      int w, h, npix, x, y, vx, vy;
      bit hit, wide;
      flag_type f;
      w = hires_cfg ? HW : LW;
      h = hires_cfg ? HH : LH;
      f = '0;
      case (op)
         OP_CLEAR: begin
            for (int r = 0; r < h; r++)
               for (int c = 0; c < w; c++) put_pix(r, c, 0);
         end
         OP_DOWN: if (n != 0 && n < h) begin
            for (int r = h - 1; r >= 0; r--)
               for (int c = 0; c < w; c++)
                  put_pix(r, c, (r >= n) ? get_pix(r - n, c) : 0);
         end
         OP_RIGHT: if (n != 0 && n < w) begin
            for (int r = 0; r < h; r++)
               for (int c = w - 1; c >= 0; c--)
                  put_pix(r, c, (c >= n) ? get_pix(r, c - n) : 0);
         end
         OP_LEFT: if (n != 0 && n < w) begin
            for (int r = 0; r < h; r++)
               for (int c = 0; c < w; c++)
                  put_pix(r, c, (c + n < w) ? get_pix(r, c + n) : 0);
         end
         OP_NARROW, OP_WIDE: begin
            wide = (op == OP_WIDE);
            npix = wide ? WIDE_PIX : NARROW_PIX;
            vx = px % w;
            vy = py % h;
            hit = 0;
            if (ri == 0) hit_rows = 0;
            for (int j = 0; j < npix; j++) begin
               x = vx + j;
               y = vy + ri;
               if (bits[npix - 1 - j]) begin
                  if (!wide && ((j > 0 && x >= w) || (ri > 0 && y >= h))) begin
                     hit = 1;
                  end else if (get_pix(y % h, x % w)) begin
                     put_pix(y % h, x % w, 0);
                     hit = 1;
                  end else begin
                     put_pix(y % h, x % w, 1);
                  end
               end
            end
            if (hit && hit_rows < FLAG_MAX) hit_rows++;
            f.draw_flag = hires_cfg ? hit_rows : 5'(hit_rows != 0);
            f.flag_final = lastr;
         end
         default: ;
      endcase
      return f;
   endfunction

   always @(posedge clock) begin
      flag_type f;
      if (reset) begin
         foreach (hi_pix[p, r, c]) hi_pix[p][r][c] = 0;
         foreach (lo_pix[p, r, c]) lo_pix[p][r][c] = 0;
         hit_rows = 0;
         hires_cfg = 0;
         plane_cfg = 0;
         fail_count = 0;
         flag_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HIRES_MODE) hires_cfg = csr_data;
            else plane_cfg = csr_data;
         end
         if (req_valid && req_ready)
            flag_queue.push_back(predict_flag(req_opcode, req_pos_x, req_pos_y,
               req_row_index, req_row_bits, req_scroll_amount, req_last_row));
         if (rsp_valid && rsp_ready) begin
            if (flag_queue.size() == 0) begin
               $error("unexpected response transaction");
               fail_count++;
            end else begin
               f = flag_queue.pop_front();
               if (rsp_draw_flag !== f.draw_flag) begin
                  $error("draw_flag expected %0d actual %0d", f.draw_flag, rsp_draw_flag);
                  fail_count++;
               end
               if (rsp_flag_final !== f.flag_final) begin
                  $error("flag_final expected %0d actual %0d", f.flag_final,
                         rsp_flag_final);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import sxfb_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_opcode = 0;
   logic [7:0] req_pos_x = 0;
   logic [7:0] req_pos_y = 0;
   logic [3:0] req_row_index = 0;
   logic [15:0] req_row_bits = 0;
   logic [3:0] req_scroll_amount = 0;
   logic req_last_row = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [4:0] rsp_draw_flag;
   logic rsp_flag_final;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_index = 0;
   logic csr_data = 0;
   int fail_count;
   int pending_flags;
   bit long_hold = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   sprite_xor_frame_buffer_top uut (.*);
   sxfb_checker chk (.*);

   // Leaves valid high after the accepting edge so the next transaction can follow
   // at once; req_gap and drain drop it.
   task automatic send_cmd(logic [2:0] op, logic [7:0] px, logic [7:0] py, logic [3:0] ri,
                           logic [15:0] bits, logic [3:0] n, logic lastr);
      req_valid <= 1;
      req_opcode <= op;
      req_pos_x <= px;
      req_pos_y <= py;
      req_row_index <= ri;
      req_row_bits <= bits;
      req_scroll_amount <= n;
      req_last_row <= lastr;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic req_gap(int cycles);
      req_valid <= 0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_flags != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Sends one sprite of random shape; its last row has last_row set.
   task automatic send_sprite(bit wide);
      int rows;
      rows = $urandom_range(1, 16);
      for (int r = 0; r < rows; r++) begin
         send_cmd(wide ? OP_WIDE : OP_NARROW, $urandom, $urandom, 4'(r), $urandom,
                  $urandom, r == rows - 1);
         if ($urandom_range(0, 3) == 0) req_gap($urandom_range(1, 6));
      end
   endtask

   task automatic random_cmd;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) send_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 9) send_cmd(3'($urandom_range(OP_DOWN, OP_LEFT)), $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom);
      else if (pick < 11) send_cmd(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom);
      else send_cmd(3'($urandom_range(OP_NARROW, OP_WIDE)), $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
   endtask

   always @(negedge clock) begin
      if (long_hold) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
   end

   initial begin
      int sent;
      repeat (2) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // Directed: extremes, each opcode, clipping and wrap cases.
      send_cmd(OP_NARROW, 8'd63, 8'd31, 0, 16'h00FF, 0, 0);
      send_cmd(OP_NARROW, 8'd63, 8'd31, 1, 16'h0081, 0, 0);
      send_cmd(OP_NARROW, 8'd255, 8'd255, 2, 16'h00FF, 0, 1);
      send_cmd(OP_WIDE, 8'd60, 8'd30, 0, 16'hFFFF, 0, 0);
      send_cmd(OP_WIDE, 8'd60, 8'd30, 1, 16'hFFFF, 0, 1);
      send_cmd(OP_DOWN, 0, 0, 0, 0, 4'd0, 0);
      send_cmd(OP_DOWN, 0, 0, 0, 0, 4'd15, 0);
      send_cmd(OP_RIGHT, 0, 0, 0, 0, 4'd1, 0);
      send_cmd(OP_LEFT, 0, 0, 0, 0, 4'd4, 0);
      send_cmd(3'd6, 8'hFF, 8'hFF, 4'hF, 16'hFFFF, 4'hF, 1);
      send_cmd(3'd7, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      drain();
      write_csr(CSR_HIRES_MODE, 1);
      write_csr(CSR_PLANE_SELECT, 1);
      csr_valid <= 0;
      for (int r = 0; r < 16; r++) send_cmd(OP_WIDE, 8'd0, 8'd0, 4'(r), 16'hFFFF, 0, r == 15);
      for (int r = 0; r < 16; r++) send_cmd(OP_WIDE, 8'd0, 8'd0, 4'(r), 16'hFFFF, 0, r == 15);
      send_cmd(OP_NARROW, 8'd127, 8'd63, 1, 16'h00FF, 0, 1);
      send_cmd(OP_DOWN, 0, 0, 0, 0, 4'd15, 0);
      drain();
      sent = 0;
      for (int phase = 0; phase < 8; phase++) begin
         write_csr(CSR_HIRES_MODE, phase[0]);
         write_csr(CSR_PLANE_SELECT, phase[1]);
         csr_valid <= 0;
         for (int k = 0; k < 160; k++) begin
            if ($urandom_range(0, 9) < 7) begin
               send_sprite($urandom_range(0, 1));
               sent += 8;
            end else begin
               random_cmd();
               sent++;
            end
            if ($urandom_range(0, 4) == 0) req_gap($urandom_range(1, 20));
            if (sent > 170 * (phase + 1)) break;
         end
         if (phase == 3) begin
            // Hold the response side for a while so the block backs up.
            long_hold = 1;
            fork
               begin
                  repeat (300) @(negedge clock);
                  long_hold = 0;
               end
               for (int k = 0; k < 6; k++) random_cmd();
            join
         end
         drain();
      end
      if (fail_count == 0) $display("sprite_xor_frame_buffer_top test passed");
      else $display("sprite_xor_frame_buffer_top test failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("sprite_xor_frame_buffer_top test failed");
      $finish;
   end
endmodule

@@ sprite_xor_frame_buffer_top.f @@
design/sxfb_pkg.sv
design/sxfb_row_ram.sv
design/sxfb_mask.sv
design/sprite_xor_frame_buffer_top.sv
bench/sxfb_checker.sv
bench/tb.sv
